// File: src/oss_pkg.sv
// Shared constants, types and codes for the orthogonal segment sweep set.
`default_nettype none
package oss_pkg;

    // Set size and coordinate width
    localparam int CAPACITY   = 64;
    localparam int COORD_BITS = 16;

    typedef logic [COORD_BITS-1:0] t_coord;

    // Input action codes
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_QUERY  = 2'd2;

    // Result kind codes
    localparam logic [2:0] KIND_INSERTED  = 3'd0;
    localparam logic [2:0] KIND_DUPLICATE = 3'd1;
    localparam logic [2:0] KIND_FULL      = 3'd2;
    localparam logic [2:0] KIND_DELETED   = 3'd3;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd4;
    localparam logic [2:0] KIND_HIT       = 3'd5;
    localparam logic [2:0] KIND_NONE      = 3'd6;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic   ins;    // insert key in sorted place
        logic   del;    // remove key, close the gap
        logic   load;   // copy row into scan chain
        logic   shift;  // move scan chain one cell toward cell 0
        t_coord key;
        t_coord lo;
        t_coord hi;
    } t_cell_ctl;

    // Status a cell shows to its neighbors and to the controller
    typedef struct packed {
        logic valid;    // entry holds an x
        logic gt;       // entry is greater than key
        logic match;    // entry equals key
        logic inr;      // entry lies inside [lo, hi]
        logic shit;     // scan chain entry is a hit
    } t_cell_stat;

endpackage
`default_nettype wire

// File: src/oss_cell.sv
// One cell of the sorted active-set row plus its scan-chain stage.
`default_nettype none
module oss_cell import oss_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cell_ctl  i_ctl,
    input  wire t_coord     i_left_x,
    input  wire t_cell_stat i_left,
    input  wire t_coord     i_right_x,
    input  wire t_coord     i_right_sx,
    input  wire t_cell_stat i_right,
    output t_coord          o_x,
    output t_coord          o_sx,
    output t_cell_stat      o_stat
);

    t_coord r_x, n_x, r_sx, n_sx;
    logic   r_valid, n_valid, r_shit, n_shit;
    logic   w_gt, w_ge;

    // Compare the held entry against the broadcast key and range
    assign w_gt = r_valid && (r_x > i_ctl.key);
    assign w_ge = r_valid && (r_x >= i_ctl.key);

    assign o_stat.valid = r_valid;
    assign o_stat.gt    = w_gt;
    assign o_stat.match = r_valid && (r_x == i_ctl.key);
    assign o_stat.inr   = r_valid && (r_x >= i_ctl.lo) && (r_x <= i_ctl.hi);
    assign o_stat.shit  = r_shit;
    assign o_x          = r_x;
    assign o_sx         = r_sx;

    // Insert opens a slot by shifting right; delete closes it by shifting left
    always_comb begin
        n_x     = r_x;
        n_valid = r_valid;
        if (i_ctl.ins && (w_gt || (!r_valid && i_left.valid))) begin
            n_x     = i_left.gt ? i_left_x : i_ctl.key;
            n_valid = 1'b1;
        end else if (i_ctl.del && w_ge) begin
            n_x     = i_right_x;
            n_valid = i_right.valid;
        end
    end

    // Load the scan chain from the row, or advance it toward cell 0
    always_comb begin
        n_sx   = r_sx;
        n_shit = r_shit;
        if (i_ctl.load) begin
            n_sx   = r_x;
            n_shit = o_stat.inr;
        end else if (i_ctl.shift) begin
            n_sx   = i_right_sx;
            n_shit = i_right.shit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_shit  <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_shit  <= n_shit;
        end
        r_x  <= n_x;
        r_sx <= n_sx;
    end

endmodule
`default_nettype wire

// File: src/orthogonal_segment_sweep_set.sv
// Top level: sweep-line active set of vertical x values with range queries.
//
// Usage: drive i_action, i_x_a, i_x_b, i_y_pos with start high; the word is
// taken at a clock edge where busy is low. Results leave on o_kind, o_hit_x,
// o_hit_y, o_last, each marked by o_strobe for exactly one cycle; o_last
// flags the final result of a word. The receiver cannot stall the block.
//
// The set is a row of CAPACITY cells kept sorted ascending and packed toward
// cell 0. Insert and delete compare the key in every cell at once and shift
// the row by one cell: the result comes in the cycle after the word's execute
// cycle, and busy drops with it. A query copies the row into a scan chain
// that moves one cell per cycle toward cell 0, where hits are emitted in
// ascending x; a query without a hit gives one "none" result. Unused action
// code 3 gives no result.
//
// Reset clears all valid bits, so the set starts empty; no clearing pass.
`default_nettype none
module orthogonal_segment_sweep_set import oss_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_action,
    input  wire t_coord      i_x_a,
    input  wire t_coord      i_x_b,
    input  wire t_coord      i_y_pos,
    output logic             o_strobe,
    output logic [2:0]       o_kind,
    output t_coord           o_hit_x,
    output t_coord           o_hit_y,
    output logic             o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0] r_state, n_state;
    logic [1:0] r_act;
    t_coord     r_key, r_lo, r_hi, r_y;

    logic       r_strobe, n_strobe, r_last, n_last;
    logic [2:0] r_kind, n_kind;
    t_coord     r_hit_x, n_hit_x, r_hit_y, n_hit_y;

    t_cell_ctl  w_ctl;
    t_coord     w_x  [CAPACITY];
    t_coord     w_sx [CAPACITY];
    t_cell_stat w_stat [CAPACITY];
    logic [CAPACITY-1:0] w_valid, w_match, w_inr, w_shit;

    logic w_accept, w_dup, w_full, w_any, w_exec, w_scan;

    assign w_accept = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign w_exec   = (r_state == ST_EXEC);
    assign w_scan   = (r_state == ST_SCAN);

    // Latch the word; order the query ends
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_action;
            r_key <= i_x_a;
            r_y   <= i_y_pos;
            r_lo  <= (i_x_a < i_x_b) ? i_x_a : i_x_b;
            r_hi  <= (i_x_a < i_x_b) ? i_x_b : i_x_a;
        end
    end

    // Gather cell status into vectors
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_valid[i] = w_stat[i].valid;
            w_match[i] = w_stat[i].match;
            w_inr[i]   = w_stat[i].inr;
            w_shit[i]  = w_stat[i].shit;
        end
    end

    assign w_dup  = |w_match;
    assign w_full = w_valid[CAPACITY-1];
    assign w_any  = |w_inr;

    // Broadcast command to the row
    always_comb begin
        w_ctl.ins   = w_exec && (r_act == ACT_INSERT) && !w_dup && !w_full;
        w_ctl.del   = w_exec && (r_act == ACT_DELETE) && w_dup;
        w_ctl.load  = w_exec && (r_act == ACT_QUERY);
        w_ctl.shift = w_scan;
        w_ctl.key   = r_key;
        w_ctl.lo    = r_lo;
        w_ctl.hi    = r_hi;
    end

    // Row of cells, each linked to its neighbors
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_coord     w_lx, w_rx, w_rsx;
        t_cell_stat w_ls, w_rs;
        if (g == 0) begin : g_first
            assign w_lx = '0;
            assign w_ls = '{valid: 1'b1, gt: 1'b0, match: 1'b0, inr: 1'b0, shit: 1'b0};
        end else begin : g_mid_l
            assign w_lx = w_x[g-1];
            assign w_ls = w_stat[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_rx  = '0;
            assign w_rsx = '0;
            assign w_rs  = '0;
        end else begin : g_mid_r
            assign w_rx  = w_x[g+1];
            assign w_rsx = w_sx[g+1];
            assign w_rs  = w_stat[g+1];
        end
        oss_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_left_x   (w_lx),
            .i_left     (w_ls),
            .i_right_x  (w_rx),
            .i_right_sx (w_rsx),
            .i_right    (w_rs),
            .o_x        (w_x[g]),
            .o_sx       (w_sx[g]),
            .o_stat     (w_stat[g])
        );
    end

    // Sequence the word and form the next result
    always_comb begin
        n_state  = r_state;
        n_strobe = 1'b0;
        n_kind   = KIND_NONE;
        n_hit_x  = '0;
        n_hit_y  = '0;
        n_last   = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
                unique case (r_act)
                    ACT_INSERT: begin
                        n_strobe = 1'b1;
                        n_kind   = w_dup ? KIND_DUPLICATE :
                                   (w_full ? KIND_FULL : KIND_INSERTED);
                    end
                    ACT_DELETE: begin
                        n_strobe = 1'b1;
                        n_kind   = w_dup ? KIND_DELETED : KIND_NOT_FOUND;
                    end
                    ACT_QUERY: begin
                        if (w_any) begin
                            n_state = ST_SCAN;
                        end else begin
                            n_strobe = 1'b1;
                            n_kind   = KIND_NONE;
                        end
                    end
                    default: ;
                endcase
            end
            ST_SCAN: begin
                if (w_shit[0]) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_HIT;
                    n_hit_x  = w_sx[0];
                    n_hit_y  = r_y;
                    n_last   = !w_shit[1];
                    if (!w_shit[1]) n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
        r_kind  <= n_kind;
        r_hit_x <= n_hit_x;
        r_hit_y <= n_hit_y;
        r_last  <= n_last;
    end

    assign o_strobe = r_strobe;
    assign o_kind   = r_kind;
    assign o_hit_x  = r_hit_x;
    assign o_hit_y  = r_hit_y;
    assign o_last   = r_last;

    // Occupied cells stay packed toward cell 0
    a_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((w_valid >> 1) & ~w_valid) == '0)
        else $error("active set not packed");

    // An accepted insert adds exactly one entry
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> $countones(w_valid) == $past($countones(w_valid)) + 1)
        else $error("insert did not add one entry");

    // An accepted delete removes exactly one entry
    a_delete_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.del |=> $countones(w_valid) + 1 == $past($countones(w_valid)))
        else $error("delete did not remove one entry");

    // A scan in progress always has a hit left to emit
    a_scan_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan |-> (|w_shit))
        else $error("scan running with no hits left");

    // Every result other than a hit closes its word
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && (r_kind != KIND_HIT)) |-> r_last)
        else $error("single result without last");

endmodule
`default_nettype wire
